@@ rtl/core/pmd_pkg.sv @@
// Package for the plateau midpoint detector: sizes, register indexes
// and derived widths. No dependencies.
`timescale 1ns / 1ps

package pmd_pkg;

    // Delay from a sample to its mark, in samples.
    localparam int MID_DELAY   = 128;
    // Width of one input sample, signed Q1.(SAMPLE_BITS-1).
    localparam int SAMPLE_BITS = 16;

    // Widths of the configuration registers.
    localparam int THR_W  = 16;
    localparam int HOLD_W = 16;
    localparam int CFG_W  = 16;

    // Derived widths.
    localparam int LINE_W = (MID_DELAY > 1) ? $clog2(MID_DELAY) : 1;
    localparam int BACK_W = $clog2(MID_DELAY + 1);
    localparam int RUN_W  = $clog2(2 * MID_DELAY + 1);
    localparam int CMP_W  = 32;

    // Byte-padded stream data widths.
    localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_THRESHOLD = 1'b0,
        CFG_HOLDOFF   = 1'b1
    } t_cfg_idx;

    localparam logic signed [THR_W-1:0] THRESHOLD_RESET = 16'sd16384;
    localparam logic [HOLD_W-1:0]       HOLDOFF_RESET   = '0;

endpackage

@@ rtl/core/plateau_midpoint_detector_top.sv @@
// Plateau midpoint detector, top level and only module.
// Depends on pmd_pkg for sizes and register indexes.
`timescale 1ns / 1ps

// Usage:
// Samples enter on the slave stream (i_s_*), one word per sample, and
// each sample yields exactly one mark word on the master stream (o_m_*).
// The mark is 1 when the sample MID_DELAY words earlier was the midpoint
// of a plateau, a run of two or more samples at or above the threshold.
// The block is a two-register pipeline: an input register and an output
// register. A sample accepted into the input register is processed at the next
// edge it can move on, and its mark then waits in the output register.
// Throughput is one sample per clock while the receiver takes every mark word;
// the compare and the run and holdoff counters fit between the two registers.
// When the receiver stalls, the output word holds and the input register
// still takes one more sample, then o_s_tready falls until the output
// drains. Nothing is dropped.
// Synchronous active-low reset clears the pipeline, the counters and the
// 128-entry mark line, and loads threshold 0.5 (16384) and holdoff 0.
// The first MID_DELAY marks after reset are 0.
// Configuration writes (i_cfg_we) take effect at once and are meant to
// be made while no samples are in flight.
module plateau_midpoint_detector_top
    import pmd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,

    // Sample stream in. tdata: [15:0] sample.
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,

    // Mark stream out. tdata: [0] mark, [7:1] zero.
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    // Configuration registers.
    logic signed [THR_W-1:0]       r_threshold;
    logic [HOLD_W-1:0]             r_holdoff_len;

    // Pipeline registers.
    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_out_valid;
    logic                          r_out_mark;

    // Detector state. The mark line is a shift register: bit 0 holds the
    // mark of the sample MID_DELAY steps back, the top bit the newest one.
    logic [RUN_W-1:0]              r_run_len;
    logic [HOLD_W-1:0]             r_holdoff_cnt;
    logic [MID_DELAY-1:0]          r_mark_line;

    // Next values.
    logic [RUN_W-1:0]              n_run_len;
    logic [HOLD_W-1:0]             n_holdoff_cnt;
    logic [MID_DELAY-1:0]          n_mark_line;
    logic                          n_out_mark;

    logic                          s_accept;
    logic                          proc;
    logic                          is_high;
    logic [RUN_W-1:0]              run_inc;
    logic [BACK_W-1:0]             back;
    logic [LINE_W-1:0]             wr_idx;
    logic signed [CMP_W-1:0]       s_aligned;
    logic signed [CMP_W-1:0]       t_aligned;

    // Handshake: the processing step moves when the output slot is free.
    assign proc       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || proc;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W-1){1'b0}}, r_out_mark};

    // Both values aligned to Q1.31 for the level compare.
    assign s_aligned = {r_sample, {(CMP_W-SAMPLE_BITS){1'b0}}};
    assign t_aligned = {r_threshold, {(CMP_W-THR_W){1'b0}}};
    assign is_high   = (s_aligned >= t_aligned);
    assign run_inc   = r_run_len + RUN_W'(1);

    // Run and holdoff update, and the distance back to a midpoint.
    always_comb begin
        n_run_len     = r_run_len;
        n_holdoff_cnt = r_holdoff_cnt;
        back          = '0;
        if (r_holdoff_cnt != '0) begin
            n_holdoff_cnt = r_holdoff_cnt - HOLD_W'(1);
        end else if (is_high) begin
            n_run_len = run_inc;
            if (run_inc >= RUN_W'(2 * MID_DELAY)) begin
                // Long run closed here, midpoint MID_DELAY - 1 samples back.
                back          = BACK_W'(MID_DELAY - 1);
                n_run_len     = '0;
                n_holdoff_cnt = r_holdoff_len;
            end
        end else begin
            if (r_run_len > RUN_W'(1)) begin
                // Ceiling of half the run.
                back          = BACK_W'(r_run_len - (r_run_len >> 1));
                n_holdoff_cnt = r_holdoff_len;
            end
            n_run_len = '0;
        end
    end

    // Line bit of the midpoint after this step's shift. A midpoint a full
    // line length back leaves the line in this same step.
    assign wr_idx = LINE_W'(MID_DELAY - 1) - LINE_W'(back);

    // Mark line: emit the oldest bit, shift, and set the midpoint.
    always_comb begin
        n_out_mark  = r_mark_line[0] || (back == BACK_W'(MID_DELAY));
        n_mark_line = {1'b0, r_mark_line[MID_DELAY-1:1]};
        if ((back != '0) && (back != BACK_W'(MID_DELAY))) begin
            n_mark_line[wr_idx] = 1'b1;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= THRESHOLD_RESET;
            r_holdoff_len <= HOLDOFF_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESHOLD: r_threshold   <= THR_W'(i_cfg_data);
                CFG_HOLDOFF:   r_holdoff_len <= HOLD_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Pipeline control and detector state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_run_len     <= '0;
            r_holdoff_cnt <= '0;
            r_mark_line   <= '0;
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_out_valid   <= 1'b1;
                r_run_len     <= n_run_len;
                r_holdoff_cnt <= n_holdoff_cnt;
                r_mark_line   <= n_mark_line;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_sample <= SAMPLE_BITS'(i_s_tdata);
        end
        if (proc) begin
            r_out_mark <= n_out_mark;
        end
    end

    // A run never stays open at twice the line length.
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_len < RUN_W'(2 * MID_DELAY))
        else $error("run length reached its closing value");

    // During holdoff no run is open.
    a_holdoff_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_holdoff_cnt != '0) |-> (r_run_len == '0))
        else $error("run open during holdoff");

    // The newest line bit is never set, since a midpoint is at least one
    // sample back.
    a_newest_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_mark_line[MID_DELAY-1])
        else $error("newest mark line bit set");

    // The mark line moves only on a processing step.
    a_line_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !proc |=> $stable(r_mark_line))
        else $error("mark line moved without a sample");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("output word changed while stalled");

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for plateau_midpoint_detector_top.
// Predicts each mark word from the sample stream and register writes; depends
// only on pmd_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb;
    import pmd_pkg::*;

    localparam int DRAIN_LIMIT = 5000;
    localparam int SETTLE      = 4;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 cfg_we   = 1'b0;
    t_cfg_idx             cfg_idx  = CFG_THRESHOLD;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tready = 1'b0;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [M_TDATA_W-1:0] o_m_tdata;

    // Traffic shaping, set by the test tasks.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stall_request  = 0;
    int stall_left     = 0;

    // Predictor state: registers, run and holdoff counters, delayed marks.
    logic signed [THR_W-1:0] thr_q;
    logic [HOLD_W-1:0]       hold_len_q;
    logic [RUN_W-1:0]        run_len_q;
    logic [HOLD_W:0]         hold_left_q;
    logic [MID_DELAY-1:0]    mark_line_q;
    int                      line_pos_q;
    bit                      expected_marks[$];

    int err_count   = 0;
    int n_samples   = 0;
    int n_marks     = 0;
    int n_mark_ones = 0;

    plateau_midpoint_detector_top u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),    // [15:0] sample
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)   // [0] mark, [7:1] zero
    );

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        #6_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= 40) $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Runs one sample through the plateau tracker and returns the mark that
    // leaves the delay line at this step.
    function automatic logic predict_mark(input logic signed [SAMPLE_BITS-1:0] smp);
        int   back;
        logic mark;
        back = 0;
        // Both operands are Q1.15, so a plain signed compare is exact.
        if (hold_left_q != 0) begin
            hold_left_q = hold_left_q - 1'b1;
        end else if (smp >= thr_q) begin
            run_len_q = run_len_q + 1'b1;
            if (run_len_q >= 2 * MID_DELAY) begin
                back        = MID_DELAY - 1;
                run_len_q   = '0;
                hold_left_q = {1'b0, hold_len_q};
            end
        end else begin
            if (run_len_q > 1) begin
                back        = int'(run_len_q) - int'(run_len_q) / 2;
                hold_left_q = {1'b0, hold_len_q};
            end
            run_len_q = '0;
        end
        if (back >= 1 && back <= MID_DELAY)
            mark_line_q[(line_pos_q + MID_DELAY - back) % MID_DELAY] = 1'b1;
        mark                    = mark_line_q[line_pos_q];
        mark_line_q[line_pos_q] = 1'b0;
        line_pos_q              = (line_pos_q + 1) % MID_DELAY;
        return mark;
    endfunction

    // Tracks register writes and accepted samples, and checks every mark word.
    always @(posedge clk) begin : scoreboard
        logic want;
        if (!rst_n) begin
            thr_q       = THRESHOLD_RESET;
            hold_len_q  = HOLDOFF_RESET;
            run_len_q   = '0;
            hold_left_q = '0;
            mark_line_q = '0;
            line_pos_q  = 0;
            expected_marks.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_THRESHOLD: thr_q      = cfg_data;
                    CFG_HOLDOFF:   hold_len_q = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && o_s_tready) begin
                expected_marks.push_back(predict_mark(s_tdata[SAMPLE_BITS-1:0]));
                n_samples++;
            end
            if (o_m_tvalid && m_tready) begin
                n_marks++;
                if (o_m_tdata[0]) n_mark_ones++;
                if (expected_marks.size() == 0) begin
                    report_mismatch($sformatf("mark word %0d with none expected", n_marks));
                end else begin
                    want = expected_marks.pop_front();
                    if (o_m_tdata[0] !== want)
                        report_mismatch($sformatf("mark word %0d: got %b, expected %b",
                                                  n_marks, o_m_tdata[0], want));
                    if (o_m_tdata[M_TDATA_W-1:1] !== '0)
                        report_mismatch($sformatf("mark word %0d: pad bits %b",
                                                  n_marks, o_m_tdata[M_TDATA_W-1:1]));
                end
            end
        end
    end

    // Receiver side: random stalls, plus long hold-offs on request.
    always @(posedge clk) begin
        if (stall_request != 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic set_register(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int thr, input int hold);
        set_register(CFG_THRESHOLD, CFG_W'(thr));
        set_register(CFG_HOLDOFF, CFG_W'(hold));
    endtask

    // Offers one sample word, idling first at the current rate.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(smp);
        @(posedge clk);
        while (!o_s_tready) @(posedge clk);
    endtask

    // Stops sending and waits until every expected mark has arrived.
    task automatic wait_marks_drained();
        int n;
        s_tvalid <= 1'b0;
        @(posedge clk);
        n = 0;
        while (expected_marks.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge clk);
            n++;
        end
        if (expected_marks.size() != 0) begin
            report_mismatch($sformatf("%0d marks never arrived", expected_marks.size()));
            expected_marks.delete();
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] high_sample();
        int t;
        t = int'(thr_q);
        return SAMPLE_BITS'(int'($urandom_range(32767 - t)) + t);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] low_sample();
        int t;
        t = int'(thr_q);
        if (t == -32768) return SAMPLE_BITS'(t);
        return SAMPLE_BITS'(int'($urandom_range(t + 32767)) - 32768);
    endfunction

    task automatic send_list(input int vals[$]);
        foreach (vals[i]) send_sample(SAMPLE_BITS'(vals[i]));
    endtask

    // Mostly well-formed plateaus with random content, mixed with single-sample
    // runs and plain noise.
    task automatic send_random_stream(input int n_items);
        int sent;
        int kind;
        int len;
        int gap;
        int r;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(99);
            if (kind < 60) begin
                r = $urandom_range(9);
                if (r < 7)      len = $urandom_range(12, 2);
                else if (r < 9) len = $urandom_range(40, 13);
                else            len = $urandom_range(120, 41);
                gap = $urandom_range(6, 1) + ((hold_len_q < 16) ? int'(hold_len_q) : 16);
                repeat (len) send_sample(high_sample());
                repeat (gap) send_sample(low_sample());
                sent += len + gap;
            end else if (kind < 75) begin
                send_sample(high_sample());
                send_sample(low_sample());
                sent += 2;
            end else begin
                len = $urandom_range(8, 1);
                repeat (len) send_sample(SAMPLE_BITS'($urandom));
                sent += len;
            end
        end
    endtask

    // Default registers: field extremes, a dropped single-sample run, and
    // plateaus of two, three and four samples.
    task automatic test_default_plateaus();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_list('{16384, 16383, 32767, -32768, 32767, 16384, -32768,
                    16384, 30000, 20000, 0, 16384, 16384, 16384, 16384, -1});
        wait_marks_drained();
    endtask

    // Holdoff at its top value with no plateau closing, then a short holdoff
    // that swallows high samples after each plateau.
    task automatic test_holdoff();
        configure(32767, 65535);
        send_list('{32767, 32766, -32768, 32767});
        wait_marks_drained();
        configure(0, 3);
        send_list('{100, 200, 300, -5, 32767, 32767, 32767, 1, 2, -32768,
                    5, 5, 5, -1});
        wait_marks_drained();
    endtask

    // A run closed at its maximum length, a run one short of it ended by a
    // low sample, and runs carried across threshold changes at both extremes.
    task automatic test_long_runs();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(0, 5);
        repeat (2 * MID_DELAY) send_sample(high_sample());
        repeat (5) send_sample(SAMPLE_BITS'($urandom));
        repeat (2 * MID_DELAY - 1) send_sample(high_sample());
        send_sample(low_sample());
        wait_marks_drained();
        configure(-32768, 0);
        repeat (30) send_sample(SAMPLE_BITS'($urandom));
        wait_marks_drained();
        configure(32767, 0);
        repeat (10) send_sample(SAMPLE_BITS'($urandom));
        wait_marks_drained();
    endtask

    // The receiver holds off long enough that the block fills and stalls its
    // input while samples keep coming.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(16384, 1);
        stall_request = 60;
        send_random_stream(30);
        wait_marks_drained();
    endtask

    // Random traffic under each idle mix, with fresh registers per phase.
    task automatic test_random_traffic();
        int idle_mix[4]  = '{0, 77, 0, 30};
        int stall_mix[4] = '{0, 0, 77, 30};
        int thr;
        int hold;
        for (int p = 0; p < 4; p++) begin
            case ($urandom_range(3))
                0:       thr = int'($urandom_range(65535)) - 32768;
                1:       thr = 32767 - int'($urandom_range(300));
                2:       thr = int'($urandom_range(300)) - 32768;
                default: thr = int'($urandom_range(8000)) - 4000;
            endcase
            hold = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(4);
            configure(thr, hold);
            send_idle_pct  = idle_mix[p];
            recv_stall_pct = stall_mix[p];
            send_random_stream(100);
            wait_marks_drained();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_plateaus();
        test_holdoff();
        test_long_runs();
        test_backpressure();
        test_random_traffic();
        wait_marks_drained();
        repeat (8) @(posedge clk);
        $display("Sent %0d samples and checked %0d marks, %0d of them set.",
                 n_samples, n_marks, n_mark_ones);
        $display("Runs: directed plateaus, holdoff, maximum-length runs, back-pressure, "
                 , "four idle mixes; %0d mismatches.", err_count);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/pmd_pkg.sv
rtl/core/plateau_midpoint_detector_top.sv
sim/tb.sv
